### rtl/core/ttint_pkg.sv
// Shared types, constants and helper functions of the thermistor table interpolator.
// Holds the built-in default breakpoint table and the sequencer state type.
// No dependencies; every other file of the block takes names from here by scope.
package ttint_pkg;

    // Configuration defaults handed to the top level parameters
    localparam int NUM_ENTRIES_DEF = 20;
    localparam int NUM_BANKS_DEF   = 2;

    // Field widths of the item payloads
    localparam int ADC_W       = 10;
    localparam int VAL_W       = 16;
    localparam int IDX_IN_W    = 5;
    localparam int ENTRY_CMP_W = 7;   // holds any entry count up to 127
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 1;

    // Arithmetic widths of the interpolation
    localparam int DEN_W         = ADC_W + 1;        // signed ADC difference
    localparam int DV_W          = VAL_W + 1;        // signed value difference
    localparam int PROD_W        = DEN_W + DV_W;     // signed product
    localparam int SUM_W         = PROD_W + 1;       // base value plus quotient
    localparam int DIV_STEP_BITS = 2;                // quotient bits per cycle
    localparam int DIV_CYCLES    = PROD_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES + 1);

    // Result limits
    localparam int CLAMP_HIGH = 255;
    localparam int CLAMP_LOW  = -32768;

    // Built-in table: {adc, celsius}
    localparam int DEFAULT_COUNT = 20;
    localparam int DFLT_IDX_W    = $clog2(DEFAULT_COUNT);

    localparam logic [ADC_W+VAL_W-1:0] DEFAULT_TAB [DEFAULT_COUNT] = '{
        {10'd1,    16'd841}, {10'd54,   16'd255}, {10'd107,  16'd209}, {10'd160,  16'd184},
        {10'd213,  16'd166}, {10'd266,  16'd153}, {10'd319,  16'd142}, {10'd372,  16'd132},
        {10'd425,  16'd124}, {10'd478,  16'd116}, {10'd531,  16'd108}, {10'd584,  16'd101},
        {10'd637,  16'd93},  {10'd690,  16'd86},  {10'd743,  16'd78},  {10'd796,  16'd70},
        {10'd849,  16'd61},  {10'd902,  16'd50},  {10'd955,  16'd34},  {10'd1008, 16'd3}
    };

    // Item kinds carried in the input tuser
    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_LOAD    = 1'b1
    } ttint_op_t;

    // One breakpoint as stored
    typedef struct packed {
        logic        [ADC_W-1:0] adc;
        logic signed [VAL_W-1:0] value;
    } ttint_bp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_FETCH_B,
        ST_FETCH_T,
        ST_EVAL,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } ttint_state_t;

    // Default breakpoint of an entry; entries past the built-in table repeat its last one
    function automatic ttint_bp_t default_entry(input logic [ENTRY_CMP_W-1:0] idx);
        ttint_bp_t e;
        if (idx < ENTRY_CMP_W'(DEFAULT_COUNT)) begin
            e = ttint_bp_t'(DEFAULT_TAB[idx[DFLT_IDX_W-1:0]]);
        end else begin
            e = ttint_bp_t'(DEFAULT_TAB[DEFAULT_COUNT-1]);
        end
        return e;
    endfunction

    // Saturate an interpolated sum to the result range
    function automatic logic signed [VAL_W-1:0] clamp_celsius(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [VAL_W-1:0] r;
        hi = SUM_W'(CLAMP_HIGH);
        lo = SUM_W'(CLAMP_LOW);
        if (v > hi) begin
            r = hi[VAL_W-1:0];
        end else if (v < lo) begin
            r = lo[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/ttint_store.sv
// Breakpoint memory of the thermistor table interpolator: all banks in one array.
// Per-entry valid bits make unwritten entries read as the default table.
// Depends on ttint_pkg.
module ttint_store #(
    parameter int NUM_ENTRIES = ttint_pkg::NUM_ENTRIES_DEF,
    parameter int NUM_BANKS   = ttint_pkg::NUM_BANKS_DEF,
    localparam int IDX_W      = $clog2(NUM_ENTRIES),
    localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [BANK_W-1:0]    wr_bank,
    input  logic [IDX_W-1:0]     wr_entry,
    input  ttint_pkg::ttint_bp_t wr_data,
    input  logic                 rd_en,
    input  logic [BANK_W-1:0]    rd_bank,
    input  logic [IDX_W-1:0]     rd_entry,
    output ttint_pkg::ttint_bp_t rd_data
);

    localparam int DEPTH  = NUM_BANKS * NUM_ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);

    ttint_pkg::ttint_bp_t mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    ttint_pkg::ttint_bp_t mem_q_reg;
    ttint_pkg::ttint_bp_t dflt_q_reg;
    logic                 hit_q_reg;
    logic [ADDR_W-1:0]    waddr;
    logic [ADDR_W-1:0]    raddr;

    // Flatten bank and entry into one address
    assign waddr = ADDR_W'(wr_bank * NUM_ENTRIES) + ADDR_W'(wr_entry);
    assign raddr = ADDR_W'(rd_bank * NUM_ENTRIES) + ADDR_W'(rd_entry);

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg  <= mem[raddr];
            hit_q_reg  <= valid_reg[raddr];
            dflt_q_reg <= ttint_pkg::default_entry(ttint_pkg::ENTRY_CMP_W'(rd_entry));
        end
    end

    // Mark entries that hold loaded data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Unwritten entries read as the default table
    assign rd_data = hit_q_reg ? mem_q_reg : dflt_q_reg;

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !rd_en)
        else $error("store read and write issued in the same cycle");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> (valid_reg == '0))
        else $error("valid bits not cleared by reset");

    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> valid_reg[$past(waddr)])
        else $error("written entry not marked valid");

endmodule

### rtl/core/ttint_div.sv
// Serial signed divider of the thermistor table interpolator, truncating toward zero.
// Restoring division on magnitudes, DIV_STEP_BITS quotient bits per cycle.
// Depends on ttint_pkg.
module ttint_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [ttint_pkg::PROD_W-1:0] dividend,
    input  logic signed [ttint_pkg::DEN_W-1:0]  divisor,
    output logic                                busy,
    output logic                                done,
    output logic signed [ttint_pkg::PROD_W-1:0] quotient
);

    localparam int PW = ttint_pkg::PROD_W;
    localparam int DW = ttint_pkg::DEN_W;
    localparam int CW = ttint_pkg::DIV_CNT_W;

    logic [DW:0]    rem_reg;
    logic [DW:0]    rem_next;
    logic [PW-1:0]  quo_reg;
    logic [PW-1:0]  quo_next;
    logic [DW-1:0]  dvs_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    // Advance the remainder and quotient by DIV_STEP_BITS bits
    always_comb begin
        logic [DW:0]   r;
        logic [PW-1:0] q;
        logic [DW:0]   t;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < ttint_pkg::DIV_STEP_BITS; k++) begin
            t = {r[DW-1:0], q[PW-1]};
            q = {q[PW-2:0], 1'b0};
            if (t >= {1'b0, dvs_reg}) begin
                t    = t - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
            r = t;
        end
        rem_next = r;
        quo_next = q;
    end

    // Load magnitudes on start, then iterate
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend[PW-1] ? PW'(-dividend) : dividend;
            dvs_reg <= divisor[DW-1] ? DW'(-divisor) : divisor;
            neg_reg <= dividend[PW-1] ^ divisor[DW-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Step counter and status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ttint_pkg::DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(PW'(-quo_reg)) : $signed(quo_reg);

endmodule

### rtl/core/thermistor_table_interpolator_core.sv
// Thermistor table interpolator. A load item (tuser op=1) writes one breakpoint of the
// selected table and gives no result; loads with an entry index at or past NUM_ENTRIES
// are dropped. A convert item (op=0) binary-searches the selected table in the
// breakpoint memory, each probe a registered read and then a compare, and then divides
// with a serial divider that retires two quotient bits per cycle. The search takes P
// probes, at most ceil(log2(NUM_ENTRIES-1)) depending on the path. Readings outside the
// table or between two equal enclosing breakpoints skip the divider.
// Out-of-scale readings return 255 with out_of_range set; other results are clamped
// above at 255. After reset every table holds the built-in default table; no clearing
// pass is needed. The output register lets the next item be accepted while a result waits.
module thermistor_table_interpolator_core #(
    parameter int NUM_ENTRIES = ttint_pkg::NUM_ENTRIES_DEF,
    parameter int NUM_BANKS   = ttint_pkg::NUM_BANKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // reading[9:0], entry_index[14:10], entry_adc[24:15], entry_value[40:25], zeros
    input  logic [ttint_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // op[0], table_sel[1]
    input  logic [ttint_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // celsius[15:0]
    output logic [ttint_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // out_of_range[0]
    output logic [ttint_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int ADC_W  = ttint_pkg::ADC_W;
    localparam int VAL_W  = ttint_pkg::VAL_W;
    localparam int CMP_W  = ttint_pkg::ENTRY_CMP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
    localparam logic [IDX_W-1:0] MID0     = IDX_W'((NUM_ENTRIES - 1) / 2);

    // Input unpacking
    ttint_pkg::ttint_op_t    in_op;
    logic                    in_sel;
    logic [ADC_W-1:0]        in_reading;
    logic [CMP_W-1:0]        in_entry;
    ttint_pkg::ttint_bp_t    in_bp;
    logic [BANK_W-1:0]       in_bank;
    logic                    s_accept;

    assign in_op       = ttint_pkg::ttint_op_t'(s_axis_tuser[0]);
    assign in_sel      = s_axis_tuser[1];
    assign in_reading  = s_axis_tdata[9:0];
    assign in_entry    = CMP_W'(s_axis_tdata[14:10]);
    assign in_bp.adc   = s_axis_tdata[24:15];
    assign in_bp.value = $signed(s_axis_tdata[40:25]);
    assign in_bank     = (NUM_BANKS == 1) ? '0 : BANK_W'(in_sel);
    assign s_accept    = s_axis_tvalid && s_axis_tready;

    ttint_pkg::ttint_state_t state_reg;
    ttint_pkg::ttint_state_t state_next;

    logic [ADC_W-1:0]                     reading_reg;
    logic [BANK_W-1:0]                    bank_reg;
    logic [IDX_W-1:0]                     bottom_reg;
    logic [IDX_W-1:0]                     top_reg;
    logic [ADC_W-1:0]                     ab_reg;
    logic signed [VAL_W-1:0]              vb_reg;
    logic signed [ttint_pkg::DEN_W-1:0]   diff_reg;
    logic signed [ttint_pkg::DV_W-1:0]    dv_reg;
    logic signed [ttint_pkg::DEN_W-1:0]   dd_reg;
    logic signed [ttint_pkg::PROD_W-1:0]  prod_reg;
    logic signed [VAL_W-1:0]              res_cel_reg;
    logic                                 res_oor_reg;
    logic signed [VAL_W-1:0]              cel_out_reg;
    logic                                 oor_out_reg;
    logic                                 m_valid_reg;

    // Store and divider handshakes
    logic                                 wr_en;
    logic                                 rd_en;
    logic [IDX_W-1:0]                     rd_entry;
    ttint_pkg::ttint_bp_t                 rd_data;
    logic                                 div_start;
    logic                                 div_busy;
    logic                                 div_done;
    logic signed [ttint_pkg::PROD_W-1:0]  div_quo;
    logic                                 out_load;

    // Search step arithmetic
    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic              probe_less;
    logic [IDX_W-1:0]  nb;
    logic [IDX_W-1:0]  nt;
    logic [IDX_W:0]    nmid_sum;
    logic [IDX_W-1:0]  nmid;

    // Interval evaluation
    logic below;
    logic above;
    logic flat;

    assign mid_sum    = {1'b0, bottom_reg} + {1'b0, top_reg};
    assign mid        = mid_sum[IDX_W:1];
    assign probe_less = reading_reg < rd_data.adc;
    assign nb         = probe_less ? bottom_reg : mid;
    assign nt         = probe_less ? mid : top_reg;
    assign nmid_sum   = {1'b0, nb} + {1'b0, nt};
    assign nmid       = nmid_sum[IDX_W:1];

    assign below = (bottom_reg == '0) && (reading_reg < ab_reg);
    assign above = (top_reg == LAST_IDX) && (reading_reg > rd_data.adc);
    assign flat  = rd_data.adc == ab_reg;

    // Loads write the store on acceptance
    assign wr_en = s_accept && (in_op == ttint_pkg::OP_LOAD)
                   && (in_entry < CMP_W'(NUM_ENTRIES));

    ttint_store #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_BANKS   (NUM_BANKS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_bank  (in_bank),
        .wr_entry (in_entry[IDX_W-1:0]),
        .wr_data  (in_bp),
        .rd_en    (rd_en),
        .rd_bank  (bank_reg),
        .rd_entry (rd_entry),
        .rd_data  (rd_data)
    );

    ttint_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dd_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttint_pkg::ST_IDLE: begin
                if (s_accept && (in_op == ttint_pkg::OP_CONVERT)) begin
                    state_next = (MID0 > '0) ? ttint_pkg::ST_PROBE_RD : ttint_pkg::ST_FETCH_B;
                end
            end
            ttint_pkg::ST_PROBE_RD: state_next = ttint_pkg::ST_PROBE_CMP;
            ttint_pkg::ST_PROBE_CMP: begin
                state_next = (nmid > nb) ? ttint_pkg::ST_PROBE_RD : ttint_pkg::ST_FETCH_B;
            end
            ttint_pkg::ST_FETCH_B: state_next = ttint_pkg::ST_FETCH_T;
            ttint_pkg::ST_FETCH_T: state_next = ttint_pkg::ST_EVAL;
            ttint_pkg::ST_EVAL: begin
                state_next = (below || above || flat) ? ttint_pkg::ST_DONE : ttint_pkg::ST_MUL;
            end
            ttint_pkg::ST_MUL:    state_next = ttint_pkg::ST_DIV_GO;
            ttint_pkg::ST_DIV_GO: state_next = ttint_pkg::ST_DIV_WAIT;
            ttint_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ttint_pkg::ST_DONE;
                end
            end
            ttint_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = ttint_pkg::ST_IDLE;
                end
            end
            default: state_next = ttint_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        rd_entry      = bottom_reg;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ttint_pkg::ST_IDLE:     s_axis_tready = 1'b1;
            ttint_pkg::ST_PROBE_RD: begin
                rd_en    = 1'b1;
                rd_entry = mid;
            end
            ttint_pkg::ST_FETCH_B: begin
                rd_en    = 1'b1;
                rd_entry = bottom_reg;
            end
            ttint_pkg::ST_FETCH_T: begin
                rd_en    = 1'b1;
                rd_entry = top_reg;
            end
            ttint_pkg::ST_DIV_GO:   div_start = 1'b1;
            ttint_pkg::ST_DONE:     out_load  = !m_valid_reg || m_axis_tready;
            ttint_pkg::ST_PROBE_CMP, ttint_pkg::ST_EVAL, ttint_pkg::ST_MUL,
            ttint_pkg::ST_DIV_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttint_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Search, interpolation and result datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ttint_pkg::ST_IDLE: begin
                if (s_accept) begin
                    reading_reg <= in_reading;
                    bank_reg    <= in_bank;
                    bottom_reg  <= '0;
                    top_reg     <= LAST_IDX;
                end
            end
            ttint_pkg::ST_PROBE_CMP: begin
                bottom_reg <= nb;
                top_reg    <= nt;
            end
            ttint_pkg::ST_FETCH_T: begin
                ab_reg <= rd_data.adc;
                vb_reg <= rd_data.value;
            end
            ttint_pkg::ST_EVAL: begin
                diff_reg <= $signed({1'b0, reading_reg}) - $signed({1'b0, ab_reg});
                dv_reg   <= ttint_pkg::DV_W'(rd_data.value) - ttint_pkg::DV_W'(vb_reg);
                dd_reg   <= $signed({1'b0, rd_data.adc}) - $signed({1'b0, ab_reg});
                if (below || above) begin
                    res_cel_reg <= VAL_W'(ttint_pkg::CLAMP_HIGH);
                    res_oor_reg <= 1'b1;
                end else begin
                    res_cel_reg <= ttint_pkg::clamp_celsius(ttint_pkg::SUM_W'(vb_reg));
                    res_oor_reg <= 1'b0;
                end
            end
            ttint_pkg::ST_MUL: begin
                prod_reg <= diff_reg * dv_reg;
            end
            ttint_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    res_cel_reg <= ttint_pkg::clamp_celsius(
                        ttint_pkg::SUM_W'(vb_reg) + ttint_pkg::SUM_W'(div_quo));
                end
            end
            ttint_pkg::ST_PROBE_RD, ttint_pkg::ST_FETCH_B, ttint_pkg::ST_DIV_GO,
            ttint_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register: load when free or being drained
    always_ff @(posedge aclk) begin
        if (out_load) begin
            cel_out_reg <= res_cel_reg;
            oor_out_reg <= res_oor_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = cel_out_reg;
    assign m_axis_tuser  = oor_out_reg;

    a_oor_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && oor_out_reg) |-> (cel_out_reg == VAL_W'(ttint_pkg::CLAMP_HIGH)))
        else $error("out-of-range result without the clamp value");

    a_probe_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ttint_pkg::ST_PROBE_RD) |-> ((mid > bottom_reg) && (mid < top_reg)))
        else $error("search probe outside the open interval");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_convert_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_op == ttint_pkg::OP_CONVERT)) |=> (state_reg != ttint_pkg::ST_IDLE))
        else $error("accepted convert item left no work in flight");

endmodule
